[rtl/sgmpa_pkg.sv]
`default_nettype none

package sgmpa_pkg;

   // Cost vector geometry
   localparam int MAX_DISP  = 64;
   localparam int DISP_W    = $clog2(MAX_DISP);
   localparam int CNT_W     = $clog2(MAX_DISP + 1);
   localparam int ADDR_W    = DISP_W + 1;
   localparam int MEM_DEPTH = 2 * MAX_DISP;

   // Field widths
   localparam int COST_W   = 16;
   localparam int MATCH_W  = 8;
   localparam int PMD_W    = 12;
   localparam int WEIGHT_W = 9;
   localparam int Q_FRAC   = 8;
   localparam int PROD_W   = COST_W + WEIGHT_W;

   // Signed width that holds a disparity index plus the alignment offset and its neighbors.
   localparam int DOFF_W = ((PMD_W > DISP_W) ? PMD_W : DISP_W) + 2;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = 9'd256;
   localparam logic [MATCH_W-1:0]  SUPPRESSED_COST = 8'd255;

   // Configuration registers
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_IDX_W    = 1;
   localparam int DISP_COUNT_W = 7;
   localparam logic [COST_W-1:0]       SMALL_JUMP_RESET = 16'd64;
   localparam logic [DISP_COUNT_W-1:0] DISP_COUNT_RESET = 7'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SMALL_JUMP = 1'b0,
      CSR_DISP_COUNT = 1'b1
   } csr_index_type;

   // Command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified item, handed from the front end to the datapath.
   typedef struct packed {
      logic                invalid;
      logic                supp;
      logic                zero;
      logic                last;
      logic [MATCH_W-1:0]  match_cost;
      logic [COST_W-1:0]   large_jump_penalty;
      logic [WEIGHT_W-1:0] weight;
      logic [COST_W-1:0]   total_in;
      logic [ADDR_W-1:0]   wr_addr;
      logic [ADDR_W-1:0]   rd_addr_same;
      logic [ADDR_W-1:0]   rd_addr_lo;
      logic [ADDR_W-1:0]   rd_addr_hi;
      logic                use_same;
      logic                use_lo;
      logic                use_hi;
      logic                zero_same;
      logic                zero_lo;
      logic                zero_hi;
   } cmd_type;

endpackage

`default_nettype wire

[rtl/sgmpa_if.sv]
`default_nettype none

interface sgmpa_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   path_start;
   logic                                   pixel_invalid;
   logic [sgmpa_pkg::MATCH_W-1:0]          match_cost;
   logic signed [sgmpa_pkg::PMD_W-1:0]     pixel_min_disp;
   logic [sgmpa_pkg::COST_W-1:0]           large_jump_penalty;
   logic                                   suppress;
   logic [sgmpa_pkg::WEIGHT_W-1:0]         dir_weight_q8;
   logic [sgmpa_pkg::COST_W-1:0]           total_in;

   modport source (
      output valid, path_start, pixel_invalid, match_cost, pixel_min_disp,
             large_jump_penalty, suppress, dir_weight_q8, total_in,
      input  ready
   );
   modport sink (
      input  valid, path_start, pixel_invalid, match_cost, pixel_min_disp,
             large_jump_penalty, suppress, dir_weight_q8, total_in,
      output ready
   );
endinterface

interface sgmpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sgmpa_pkg::COST_W-1:0]  path_cost;
   logic [sgmpa_pkg::COST_W-1:0]  total_out;
   logic                          pixel_last;

   modport source (
      output valid, path_cost, total_out, pixel_last,
      input  ready
   );
   modport sink (
      input  valid, path_cost, total_out, pixel_last,
      output ready
   );
endinterface

`default_nettype wire

[rtl/sgm_path_cost_aggregation_unit.sv]
`default_nettype none

// Path: queue, cost stage, weighting stage, product stage, output register. Throughput: one item
// per cycle unless the output is held; the cost recurrence closes in a single stage that writes
// each cost back to the vector store and forwards it to the next item in the same cycle.
// Reset: synchronous; the previous cost vector reads as zero until the first pixel ends,
// the registers take their reset values and no store clearing pass is needed.
module sgm_path_cost_aggregation_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   sgmpa_req_if.sink                               req_chan,
   sgmpa_rsp_if.source                             rsp_chan,
   input  wire logic                               csr_wr_en,
   input  wire logic [sgmpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sgmpa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [sgmpa_pkg::COST_W-1:0]        p1_ff, p1_in;
   logic [sgmpa_pkg::DISP_COUNT_W-1:0]  count_ff, count_in;
   logic [sgmpa_pkg::CNT_W-1:0]         disp_count;

   logic                                q_push;
   sgmpa_pkg::cmd_type                  q_push_item;
   logic                                q_full;
   logic                                q_pop;
   logic                                q_valid;
   sgmpa_pkg::cmd_type                  q_head;

   always_comb begin
      p1_in    = p1_ff;
      count_in = count_ff;
      if (csr_wr_en) begin
         case (sgmpa_pkg::csr_index_type'(csr_index))
            sgmpa_pkg::CSR_SMALL_JUMP: begin
               p1_in = csr_wdata[sgmpa_pkg::COST_W-1:0];
            end
            sgmpa_pkg::CSR_DISP_COUNT: begin
               count_in = csr_wdata[sgmpa_pkg::DISP_COUNT_W-1:0];
            end
            default: begin
               p1_in = p1_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff    <= sgmpa_pkg::SMALL_JUMP_RESET;
         count_ff <= sgmpa_pkg::DISP_COUNT_RESET;
      end else begin
         p1_ff    <= p1_in;
         count_ff <= count_in;
      end
   end

   // A count of zero acts as one, and a count above the vector size as the vector size.
   always_comb begin
      if (count_ff == '0) begin
         disp_count = sgmpa_pkg::CNT_W'(1);
      end else if (32'(count_ff) > sgmpa_pkg::MAX_DISP) begin
         disp_count = sgmpa_pkg::CNT_W'(sgmpa_pkg::MAX_DISP);
      end else begin
         disp_count = sgmpa_pkg::CNT_W'(count_ff);
      end
   end

   sgmpa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .disp_count (disp_count),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_push_item)
   );

   sgmpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_head)
   );

   sgmpa_back u_back (
      .clock              (clock),
      .reset              (reset),
      .small_jump_penalty (p1_ff),
      .q_valid            (q_valid),
      .q_item             (q_head),
      .q_pop              (q_pop),
      .rsp_chan           (rsp_chan)
   );

endmodule

`default_nettype wire

[rtl/sgmpa_front.sv]
`default_nettype none

module sgmpa_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   sgmpa_req_if.sink                          req_chan,
   input  wire logic [sgmpa_pkg::CNT_W-1:0]   disp_count,
   input  wire logic                          q_full,
   output logic                               q_push,
   output sgmpa_pkg::cmd_type                 q_item
);

   logic [sgmpa_pkg::DISP_W-1:0]          cnt_ff, cnt_in;
   logic                                  prev_zero_ff, prev_zero_in;
   logic signed [sgmpa_pkg::PMD_W-1:0]    prev_pmd_ff, prev_pmd_in;
   logic [sgmpa_pkg::CNT_W-1:0]           prev_n_ff, prev_n_in;
   logic                                  wbank_ff, wbank_in;

   logic                                  accept;
   logic                                  last;
   logic                                  zero;
   logic [sgmpa_pkg::CNT_W-1:0]           n_m1;
   logic [sgmpa_pkg::DISP_W-1:0]          d;
   logic signed [sgmpa_pkg::DOFF_W-1:0]   d_ext;
   logic signed [sgmpa_pkg::DOFF_W-1:0]   off;
   logic signed [sgmpa_pkg::DOFF_W-1:0]   doff;
   logic signed [sgmpa_pkg::DOFF_W-1:0]   doff_m1;
   logic signed [sgmpa_pkg::DOFF_W-1:0]   doff_p1;
   logic signed [sgmpa_pkg::DOFF_W-1:0]   n_ext;
   logic [sgmpa_pkg::DISP_W-1:0]          idx_same;
   logic [sgmpa_pkg::DISP_W-1:0]          idx_lo;
   logic [sgmpa_pkg::DISP_W-1:0]          idx_hi;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign q_push         = accept;

   // A counter at or past the last disparity closes the pixel there.
   assign n_m1 = disp_count - sgmpa_pkg::CNT_W'(1);
   assign last = (sgmpa_pkg::CNT_W'(cnt_ff) >= n_m1);
   assign d    = last ? n_m1[sgmpa_pkg::DISP_W-1:0] : cnt_ff;
   assign zero = req_chan.path_start || prev_zero_ff;

   assign d_ext   = $signed(sgmpa_pkg::DOFF_W'(d));
   assign n_ext   = $signed(sgmpa_pkg::DOFF_W'(disp_count));
   assign off     = zero ? '0 : (sgmpa_pkg::DOFF_W'(req_chan.pixel_min_disp) -
                                 sgmpa_pkg::DOFF_W'(prev_pmd_ff));
   assign doff    = d_ext + off;
   assign doff_m1 = doff - sgmpa_pkg::DOFF_W'(1);
   assign doff_p1 = doff + sgmpa_pkg::DOFF_W'(1);

   assign idx_same = doff[sgmpa_pkg::DISP_W-1:0];
   assign idx_lo   = doff_m1[sgmpa_pkg::DISP_W-1:0];
   assign idx_hi   = doff_p1[sgmpa_pkg::DISP_W-1:0];

   always_comb begin
      q_item = '0;
      q_item.invalid            = req_chan.pixel_invalid;
      q_item.supp               = req_chan.suppress;
      q_item.zero               = zero;
      q_item.last               = last;
      q_item.match_cost         = req_chan.match_cost;
      q_item.large_jump_penalty = req_chan.large_jump_penalty;
      q_item.weight             = req_chan.dir_weight_q8[sgmpa_pkg::WEIGHT_W-1] ?
                                  sgmpa_pkg::WEIGHT_ONE : req_chan.dir_weight_q8;
      q_item.total_in           = req_chan.total_in;
      q_item.wr_addr            = {wbank_ff, d};
      q_item.rd_addr_same       = {!wbank_ff, idx_same};
      q_item.rd_addr_lo         = {!wbank_ff, idx_lo};
      q_item.rd_addr_hi         = {!wbank_ff, idx_hi};
      q_item.use_same           = (doff >= 0) && (doff < n_ext);
      q_item.use_lo             = (doff > 0) && (doff <= n_ext);
      q_item.use_hi             = (doff >= -1) && (doff < n_ext - sgmpa_pkg::DOFF_W'(1));
      // Entries beyond the count of the previous pixel read as zero.
      q_item.zero_same          = zero || (sgmpa_pkg::CNT_W'(idx_same) >= prev_n_ff);
      q_item.zero_lo            = zero || (sgmpa_pkg::CNT_W'(idx_lo) >= prev_n_ff);
      q_item.zero_hi            = zero || (sgmpa_pkg::CNT_W'(idx_hi) >= prev_n_ff);
   end

   always_comb begin
      cnt_in       = cnt_ff;
      prev_zero_in = prev_zero_ff;
      prev_pmd_in  = prev_pmd_ff;
      prev_n_in    = prev_n_ff;
      wbank_in     = wbank_ff;
      if (accept) begin
         if (last) begin
            cnt_in       = '0;
            prev_zero_in = 1'b0;
            prev_pmd_in  = req_chan.pixel_min_disp;
            prev_n_in    = disp_count;
            wbank_in     = !wbank_ff;
         end else begin
            cnt_in = d + sgmpa_pkg::DISP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         prev_zero_ff <= 1'b1;
         prev_pmd_ff  <= '0;
         prev_n_ff    <= '0;
         wbank_ff     <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         prev_zero_ff <= prev_zero_in;
         prev_pmd_ff  <= prev_pmd_in;
         prev_n_ff    <= prev_n_in;
         wbank_ff     <= wbank_in;
      end
   end

endmodule

`default_nettype wire

[rtl/sgmpa_queue.sv]
`default_nettype none

module sgmpa_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire sgmpa_pkg::cmd_type  push_item,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output sgmpa_pkg::cmd_type       head_item
);

   sgmpa_pkg::cmd_type              ent_ff [sgmpa_pkg::QUEUE_DEPTH];
   logic [sgmpa_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sgmpa_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sgmpa_pkg::QCNT_W-1:0]    count_ff, count_in;

   assign full       = (count_ff == sgmpa_pkg::QCNT_W'(sgmpa_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == sgmpa_pkg::QUEUE_DEPTH - 1) ?
                     '0 : wr_ptr_ff + sgmpa_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == sgmpa_pkg::QUEUE_DEPTH - 1) ?
                     '0 : rd_ptr_ff + sgmpa_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + sgmpa_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - sgmpa_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/sgmpa_back.sv]
`default_nettype none

module sgmpa_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [sgmpa_pkg::COST_W-1:0]  small_jump_penalty,
   input  wire logic                          q_valid,
   input  wire sgmpa_pkg::cmd_type            q_item,
   output logic                               q_pop,
   sgmpa_rsp_if.source                        rsp_chan
);

   // Three copies of the two-bank cost vector store, one per neighbor read.
   logic [sgmpa_pkg::COST_W-1:0]   mem_same [sgmpa_pkg::MEM_DEPTH];
   logic [sgmpa_pkg::COST_W-1:0]   mem_lo   [sgmpa_pkg::MEM_DEPTH];
   logic [sgmpa_pkg::COST_W-1:0]   mem_hi   [sgmpa_pkg::MEM_DEPTH];

   logic                           adv;

   // Cost stage
   logic                           b_valid_ff;
   sgmpa_pkg::cmd_type             b_item_ff;
   logic [sgmpa_pkg::COST_W-1:0]   rd_same_ff, rd_lo_ff, rd_hi_ff;
   logic                           fwd_same_hit_ff, fwd_same_hit_in;
   logic                           fwd_lo_hit_ff, fwd_lo_hit_in;
   logic                           fwd_hi_hit_ff, fwd_hi_hit_in;
   logic [sgmpa_pkg::COST_W-1:0]   fwd_val_ff;
   logic [sgmpa_pkg::COST_W-1:0]   run_min_ff, run_min_in;
   logic [sgmpa_pkg::COST_W-1:0]   prev_min_ff, prev_min_in;

   logic [sgmpa_pkg::COST_W-1:0]   pmin;
   logic [sgmpa_pkg::COST_W-1:0]   v_same, v_lo, v_hi;
   logic [sgmpa_pkg::COST_W-1:0]   cand_lo, cand_hi;
   logic [sgmpa_pkg::COST_W-1:0]   best;
   logic [sgmpa_pkg::COST_W-1:0]   app;
   logic [sgmpa_pkg::COST_W-1:0]   path_b;
   logic [sgmpa_pkg::COST_W-1:0]   lowest;

   // Weighting stage
   logic                           c_valid_ff;
   logic [sgmpa_pkg::COST_W-1:0]   c_path_ff;
   logic [sgmpa_pkg::COST_W-1:0]   c_tin_ff;
   logic                           c_supp_ff;
   logic                           c_last_ff;
   logic [sgmpa_pkg::WEIGHT_W-1:0] c_weight_ff;
   logic [sgmpa_pkg::PROD_W-1:0]   prod;

   // Product stage
   logic                           d_valid_ff;
   logic [sgmpa_pkg::COST_W-1:0]   d_path_ff;
   logic [sgmpa_pkg::COST_W-1:0]   d_tin_ff;
   logic                           d_supp_ff;
   logic                           d_last_ff;
   logic [sgmpa_pkg::COST_W-1:0]   d_scaled_ff;

   // Output register
   logic                           o_valid_ff;
   logic [sgmpa_pkg::COST_W-1:0]   o_path_ff;
   logic [sgmpa_pkg::COST_W-1:0]   o_total_ff, o_total_in;
   logic                           o_last_ff;

   // The whole datapath moves together unless the output item is held.
   assign adv   = !o_valid_ff || rsp_chan.ready;
   assign q_pop = q_valid && adv;

   // The item leaving the cost stage writes at the same edge the next one reads,
   // so a matching address takes the fresh value from the forward register.
   assign fwd_same_hit_in = b_valid_ff && q_valid && (q_item.rd_addr_same == b_item_ff.wr_addr);
   assign fwd_lo_hit_in   = b_valid_ff && q_valid && (q_item.rd_addr_lo == b_item_ff.wr_addr);
   assign fwd_hi_hit_in   = b_valid_ff && q_valid && (q_item.rd_addr_hi == b_item_ff.wr_addr);

   always_comb begin
      pmin    = b_item_ff.zero ? '0 : prev_min_ff;
      v_same  = b_item_ff.zero_same ? '0 : (fwd_same_hit_ff ? fwd_val_ff : rd_same_ff);
      v_lo    = b_item_ff.zero_lo ? '0 : (fwd_lo_hit_ff ? fwd_val_ff : rd_lo_ff);
      v_hi    = b_item_ff.zero_hi ? '0 : (fwd_hi_hit_ff ? fwd_val_ff : rd_hi_ff);
      cand_lo = v_lo + small_jump_penalty;
      cand_hi = v_hi + small_jump_penalty;
      best    = pmin + b_item_ff.large_jump_penalty;
      if (b_item_ff.use_same && (v_same < best)) begin
         best = v_same;
      end
      if (b_item_ff.use_lo && (cand_lo < best)) begin
         best = cand_lo;
      end
      if (b_item_ff.use_hi && (cand_hi < best)) begin
         best = cand_hi;
      end
      app    = b_item_ff.supp ? sgmpa_pkg::COST_W'(sgmpa_pkg::SUPPRESSED_COST) :
                                sgmpa_pkg::COST_W'(b_item_ff.match_cost);
      path_b = b_item_ff.invalid ? '0 : (app + best - pmin);
      lowest = (path_b < run_min_ff) ? path_b : run_min_ff;
   end

   always_comb begin
      run_min_in  = run_min_ff;
      prev_min_in = prev_min_ff;
      if (adv && b_valid_ff) begin
         if (b_item_ff.last) begin
            prev_min_in = lowest;
            run_min_in  = '1;
         end else begin
            run_min_in = lowest;
         end
      end
   end

   assign prod       = sgmpa_pkg::PROD_W'(c_path_ff) * sgmpa_pkg::PROD_W'(c_weight_ff);
   assign o_total_in = d_tin_ff + (d_supp_ff ? d_scaled_ff : d_path_ff);

   always_ff @(posedge clock) begin
      if (adv && b_valid_ff) begin
         mem_same[b_item_ff.wr_addr] <= path_b;
         mem_lo[b_item_ff.wr_addr]   <= path_b;
         mem_hi[b_item_ff.wr_addr]   <= path_b;
      end
      if (adv) begin
         rd_same_ff <= mem_same[q_item.rd_addr_same];
         rd_lo_ff   <= mem_lo[q_item.rd_addr_lo];
         rd_hi_ff   <= mem_hi[q_item.rd_addr_hi];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_item_ff   <= q_item;
         fwd_val_ff  <= path_b;
         c_path_ff   <= path_b;
         c_tin_ff    <= b_item_ff.total_in;
         c_supp_ff   <= b_item_ff.supp;
         c_last_ff   <= b_item_ff.last;
         c_weight_ff <= b_item_ff.weight;
         d_path_ff   <= c_path_ff;
         d_tin_ff    <= c_tin_ff;
         d_supp_ff   <= c_supp_ff;
         d_last_ff   <= c_last_ff;
         d_scaled_ff <= prod[sgmpa_pkg::Q_FRAC+sgmpa_pkg::COST_W-1:sgmpa_pkg::Q_FRAC];
         o_path_ff   <= d_path_ff;
         o_total_ff  <= o_total_in;
         o_last_ff   <= d_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff      <= 1'b0;
         c_valid_ff      <= 1'b0;
         d_valid_ff      <= 1'b0;
         o_valid_ff      <= 1'b0;
         fwd_same_hit_ff <= 1'b0;
         fwd_lo_hit_ff   <= 1'b0;
         fwd_hi_hit_ff   <= 1'b0;
         run_min_ff      <= '1;
         prev_min_ff     <= '0;
      end else begin
         if (adv) begin
            b_valid_ff      <= q_valid;
            c_valid_ff      <= b_valid_ff;
            d_valid_ff      <= c_valid_ff;
            o_valid_ff      <= d_valid_ff;
            fwd_same_hit_ff <= fwd_same_hit_in;
            fwd_lo_hit_ff   <= fwd_lo_hit_in;
            fwd_hi_hit_ff   <= fwd_hi_hit_in;
         end
         run_min_ff  <= run_min_in;
         prev_min_ff <= prev_min_in;
      end
   end

   assign rsp_chan.valid      = o_valid_ff;
   assign rsp_chan.path_cost  = o_path_ff;
   assign rsp_chan.total_out  = o_total_ff;
   assign rsp_chan.pixel_last = o_last_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(b_valid_ff) && $stable(c_valid_ff) && $stable(d_valid_ff) &&
               $stable(run_min_ff))
      else $error("datapath moved while the output item was held");

   a_min_restart: assert property (@(posedge clock) disable iff (reset)
      adv && b_valid_ff && b_item_ff.last |=> run_min_ff == {sgmpa_pkg::COST_W{1'b1}})
      else $error("running minimum not restarted at the end of a pixel");

   a_min_tracks: assert property (@(posedge clock) disable iff (reset)
      adv && b_valid_ff && !b_item_ff.last |=> run_min_ff <= $past(path_b))
      else $error("running minimum above a cost of the current pixel");

   a_fwd_needs_item: assert property (@(posedge clock) disable iff (reset)
      fwd_same_hit_ff || fwd_lo_hit_ff || fwd_hi_hit_ff |-> b_valid_ff)
      else $error("forwarded cost without an item in the cost stage");

endmodule

`default_nettype wire
